// ===== design/smrxtx_pkg.sv =====
package smrxtx_pkg;

	localparam int SILO_DEPTH_DEF = 64;
	localparam int NUM_LINES_DEF  = 8;
	localparam int ALARM_STEP_DEF = 16;

	localparam int LINE_W     = 3;
	localparam int CHAR_W     = 8;
	localparam int ACTION_W   = 3;
	localparam int CLEN_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_RX      = 3'd0,
		ACT_READ    = 3'd1,
		ACT_ENABLES = 3'd2,
		ACT_TXWR    = 3'd3,
		ACT_TXDONE  = 3'd4,
		ACT_PARAMS  = 3'd5
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCAN_EN   = 3'd0,
		CFG_RXIRQ_EN  = 3'd1,
		CFG_ALARM_MD  = 3'd2,
		CFG_TXIRQ_EN  = 3'd3,
		CFG_LOOPBACK  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} seq_state_t;

	typedef struct packed {
		logic              ovr;
		logic [LINE_W-1:0] line;
		logic [CHAR_W-1:0] ch;
	} silo_entry_t;

	// character mask for 5..8 bit lengths
	function automatic logic [CHAR_W-1:0] len_mask(input logic [CLEN_W-1:0] code);
		logic [CHAR_W-1:0] m;
		unique case (code)
			2'd0: m = 8'h1F;
			2'd1: m = 8'h3F;
			2'd2: m = 8'h7F;
			2'd3: m = 8'hFF;
			default: m = 8'hFF;
		endcase
		return m;
	endfunction

endpackage

// ===== design/smrxtx_in_if.sv =====
interface smrxtx_in_if;
	logic                                valid;
	logic                                ready;
	logic [smrxtx_pkg::ACTION_W-1:0]     action;
	logic [smrxtx_pkg::LINE_W-1:0]       line;
	logic [smrxtx_pkg::CHAR_W-1:0]       data;
	logic [7:0]                          enable_mask;
	logic [smrxtx_pkg::CLEN_W-1:0]       width_code;
	logic                                rx_on;

	modport source (output valid, action, line, data, enable_mask, width_code, rx_on,
		input ready);
	modport sink (input valid, action, line, data, enable_mask, width_code, rx_on,
		output ready);
endinterface

// ===== design/smrxtx_out_if.sv =====
interface smrxtx_out_if;
	logic                          valid;
	logic                          ready;
	logic                          buf_valid;
	logic [smrxtx_pkg::LINE_W-1:0] buf_line;
	logic                          buf_overrun;
	logic [smrxtx_pkg::CHAR_W-1:0] buf_data;
	logic                          silo_alarm;
	logic                          tx_ready_flag;
	logic [smrxtx_pkg::LINE_W-1:0] tx_select;
	logic                          rx_irq;
	logic                          tx_irq;
	logic                          tx_strobe;
	logic [smrxtx_pkg::LINE_W-1:0] tx_line;
	logic [smrxtx_pkg::CHAR_W-1:0] tx_data;

	modport source (output valid, buf_valid, buf_line, buf_overrun, buf_data, silo_alarm,
		tx_ready_flag, tx_select, rx_irq, tx_irq, tx_strobe, tx_line, tx_data,
		input ready);
	modport sink (input valid, buf_valid, buf_line, buf_overrun, buf_data, silo_alarm,
		tx_ready_flag, tx_select, rx_irq, tx_irq, tx_strobe, tx_line, tx_data,
		output ready);
endinterface

// ===== design/smrxtx_cfg_if.sv =====
interface smrxtx_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [smrxtx_pkg::CFG_IDX_W-1:0]  index;
	logic [smrxtx_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// ===== design/smrxtx_silo.sv =====
module smrxtx_silo #(
	parameter int DEPTH = smrxtx_pkg::SILO_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  smrxtx_pkg::silo_entry_t   wr_data,
	input  logic                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output smrxtx_pkg::silo_entry_t   rd_data
);

	smrxtx_pkg::silo_entry_t mem [DEPTH];
	smrxtx_pkg::silo_entry_t rd_q;
	smrxtx_pkg::silo_entry_t fwd_q;
	logic                    hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			// same-cycle write to the head entry: take the new word
			hit_q <= wr_en && (wr_addr == rd_addr);
			fwd_q <= wr_data;
		end
	end

	assign rd_data = hit_q ? fwd_q : rd_q;

endmodule

// ===== design/serial_mux_rx_silo_tx_scanner.sv =====
// Channel | Dir | Handshake     | Word
// req     | in  | valid/ready   | action, line, data, enable_mask, width_code, rx_on
// rsp     | out | valid/ready   | buffer head, alarm, scanner, irqs, transmit strobe
// cfg     | in  | valid/ready   | register index, write data (ready held high)
//
// Each word passes an execute state, which updates state and reads the silo head from the
// silo RAM (separate write and read ports), then a response state that registers the result.
// A new word is taken in the response state while rsp is free; a stalled rsp holds it off.
// Async active-low reset clears pointers, flags and per-line state; silo RAM not cleared.
module serial_mux_rx_silo_tx_scanner #(
	parameter int SILO_DEPTH = smrxtx_pkg::SILO_DEPTH_DEF,
	parameter int NUM_LINES  = smrxtx_pkg::NUM_LINES_DEF,
	parameter int ALARM_STEP = smrxtx_pkg::ALARM_STEP_DEF
) (
	input logic                clk,
	input logic                arst_n,
	smrxtx_in_if.sink          req,
	smrxtx_out_if.source       rsp,
	smrxtx_cfg_if.sink         cfg
);

	localparam int PTR_W  = $clog2(SILO_DEPTH);
	localparam int FILL_W = $clog2(SILO_DEPTH + 1);
	localparam int THR_W  = $clog2(SILO_DEPTH + ALARM_STEP + 1);
	localparam int LN_W   = $clog2(NUM_LINES);
	localparam int LW     = smrxtx_pkg::LINE_W;
	localparam int CW     = smrxtx_pkg::CHAR_W;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(SILO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(SILO_DEPTH - 1) : p - 1'b1;
	endfunction

	// sequencer
	smrxtx_pkg::seq_state_t st_q, st_d;
	logic req_rdy, exec_en, rd_en, out_load, out_free;

	// captured word
	smrxtx_pkg::action_t         action_q;
	logic [LW-1:0]               line_q;
	logic [CW-1:0]               data_q;
	logic [7:0]                  mask_q;
	logic [smrxtx_pkg::CLEN_W-1:0] clen_q;
	logic                        rxon_in_q;

	// configuration
	logic scan_en_q, rxirq_en_q, alarm_md_q, txirq_en_q, loopback_q;

	// block state
	logic [PTR_W-1:0]     head_q, head_d, tail_q, tail_d;
	logic [FILL_W-1:0]    fill_q, fill_d;
	logic [THR_W-1:0]     thr_q, thr_d;
	logic                 alarm_q, alarm_d, ready_q, ready_d;
	logic [LW-1:0]        sel_q, sel_d;
	logic [NUM_LINES-1:0] en_q, en_d, idle_q, idle_d, rxon_q, rxon_d;
	logic [smrxtx_pkg::CLEN_W-1:0] len_q [NUM_LINES];
	logic [CW-1:0]        pend_q [NUM_LINES];

	// exec-cycle signals
	logic [LW-1:0]        arr_addr;
	logic [LN_W-1:0]      arr_idx, sel_idx;
	logic                 ln_ok, sel_ok;
	logic [smrxtx_pkg::CLEN_W-1:0] len_rd;
	logic [CW-1:0]        rx_ch, tx_ch;
	logic                 rx_go, do_scan, len_we, pend_we, strobe;
	logic [NUM_LINES-1:0] ok_vec;
	logic                 found;
	logic [LW-1:0]        pick;
	logic                 wr_en;
	logic [PTR_W-1:0]     wr_addr;
	smrxtx_pkg::silo_entry_t wr_entry, head_entry;

	// result side
	logic          bufv_s2, strobe_s2;
	logic [LW-1:0] txline_s2;
	logic [CW-1:0] txdata_s2;
	logic          out_valid_q;

	// ---------------- sequencer ----------------
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			smrxtx_pkg::ST_IDLE: begin
				if (req.valid) st_d = smrxtx_pkg::ST_EXEC;
			end
			smrxtx_pkg::ST_EXEC: st_d = smrxtx_pkg::ST_RESP;
			smrxtx_pkg::ST_RESP: begin
				if (out_free) st_d = req.valid ? smrxtx_pkg::ST_EXEC : smrxtx_pkg::ST_IDLE;
			end
			default: st_d = smrxtx_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_rdy  = 1'b0;
		exec_en  = 1'b0;
		out_load = 1'b0;
		unique case (st_q)
			smrxtx_pkg::ST_IDLE: req_rdy = 1'b1;
			smrxtx_pkg::ST_EXEC: exec_en = 1'b1;
			smrxtx_pkg::ST_RESP: begin
				out_load = out_free;
				req_rdy  = out_free;
			end
			default: ;
		endcase
	end

	assign rd_en     = exec_en;
	assign req.ready = req_rdy;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= smrxtx_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req_rdy) begin
			action_q  <= smrxtx_pkg::action_t'(req.action);
			line_q    <= req.line;
			data_q    <= req.data;
			mask_q    <= req.enable_mask;
			clen_q    <= req.width_code;
			rxon_in_q <= req.rx_on;
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_en_q  <= 1'b0;
			rxirq_en_q <= 1'b0;
			alarm_md_q <= 1'b0;
			txirq_en_q <= 1'b0;
			loopback_q <= 1'b0;
		end else if (cfg.valid) begin
			case (smrxtx_pkg::cfg_reg_t'(cfg.index))
				smrxtx_pkg::CFG_SCAN_EN:  scan_en_q  <= cfg.wdata[0];
				smrxtx_pkg::CFG_RXIRQ_EN: rxirq_en_q <= cfg.wdata[0];
				smrxtx_pkg::CFG_ALARM_MD: alarm_md_q <= cfg.wdata[0];
				smrxtx_pkg::CFG_TXIRQ_EN: txirq_en_q <= cfg.wdata[0];
				smrxtx_pkg::CFG_LOOPBACK: loopback_q <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// ---------------- update logic ----------------
	// per-line tables see one address: the scanner's line for a transmit write,
	// the word's line otherwise
	assign arr_addr = (action_q == smrxtx_pkg::ACT_TXWR) ? sel_q : line_q;
	assign arr_idx  = arr_addr[LN_W-1:0];
	assign len_rd   = len_q[arr_idx];
	assign ln_ok    = line_q < NUM_LINES;
	assign sel_ok   = sel_q < NUM_LINES;
	assign tx_ch    = data_q & smrxtx_pkg::len_mask(len_rd);

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		fill_d   = fill_q;
		thr_d    = thr_q;
		alarm_d  = alarm_q;
		ready_d  = ready_q;
		sel_d    = sel_q;
		en_d     = en_q;
		idle_d   = idle_q;
		rxon_d   = rxon_q;
		len_we   = 1'b0;
		pend_we  = 1'b0;
		strobe   = 1'b0;
		rx_go    = 1'b0;
		do_scan  = 1'b0;
		rx_ch    = data_q;
		wr_en    = 1'b0;
		wr_addr  = head_q;
		wr_entry = '0;
		ok_vec   = '0;
		found    = 1'b0;
		pick     = '0;
		sel_idx  = '0;

		case (action_q)
			smrxtx_pkg::ACT_RX: rx_go = ln_ok;
			smrxtx_pkg::ACT_READ: begin
				alarm_d = 1'b0;
				if (fill_q != '0) begin
					tail_d = ptr_next(tail_q);
					fill_d = fill_q - 1'b1;
				end
				thr_d = THR_W'(fill_d) + THR_W'(ALARM_STEP);
			end
			smrxtx_pkg::ACT_ENABLES: begin
				en_d    = mask_q[NUM_LINES-1:0];
				do_scan = 1'b1;
			end
			smrxtx_pkg::ACT_TXWR: begin
				ready_d = 1'b0;
				if (sel_ok && idle_q[arr_idx]) begin
					idle_d[arr_idx] = 1'b0;
					pend_we = 1'b1;
					strobe  = 1'b1;
				end
				do_scan = 1'b1;
			end
			smrxtx_pkg::ACT_TXDONE: begin
				if (ln_ok && !idle_q[arr_idx]) begin
					rx_go           = loopback_q;
					rx_ch           = pend_q[arr_idx];
					idle_d[arr_idx] = 1'b1;
					do_scan         = 1'b1;
				end
			end
			smrxtx_pkg::ACT_PARAMS: begin
				if (ln_ok) begin
					len_we          = 1'b1;
					rxon_d[arr_idx] = rxon_in_q;
				end
			end
			default: ;
		endcase

		// silo insert; full silo overwrites the newest entry
		if (rx_go && scan_en_q && rxon_q[arr_idx]) begin
			wr_en         = 1'b1;
			wr_entry.line = line_q;
			wr_entry.ch   = rx_ch & smrxtx_pkg::len_mask(len_rd);
			if (fill_q < FILL_W'(SILO_DEPTH)) begin
				wr_entry.ovr = 1'b0;
				head_d       = ptr_next(head_q);
				fill_d       = fill_q + 1'b1;
				if (THR_W'(fill_d) >= thr_q) alarm_d = 1'b1;
			end else begin
				wr_addr      = ptr_prev(head_q);
				wr_entry.ovr = 1'b1;
			end
		end

		// transmit scanner: keep a still-usable choice, else highest enabled idle line
		ok_vec  = en_d & idle_d;
		sel_idx = sel_d[LN_W-1:0];
		for (int i = 0; i < NUM_LINES; i++) begin
			if (ok_vec[i]) begin
				found = 1'b1;
				pick  = LW'(i);
			end
		end
		if (do_scan && !(ready_d && (sel_d < NUM_LINES) && ok_vec[sel_idx])) begin
			ready_d = found;
			if (found) sel_d = pick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			thr_q   <= THR_W'(ALARM_STEP);
			alarm_q <= 1'b0;
			ready_q <= 1'b0;
			sel_q   <= '0;
			en_q    <= '0;
			idle_q  <= '1;
			rxon_q  <= '0;
			for (int i = 0; i < NUM_LINES; i++) begin
				len_q[i]  <= '0;
				pend_q[i] <= '0;
			end
		end else if (exec_en) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			fill_q  <= fill_d;
			thr_q   <= thr_d;
			alarm_q <= alarm_d;
			ready_q <= ready_d;
			sel_q   <= sel_d;
			en_q    <= en_d;
			idle_q  <= idle_d;
			rxon_q  <= rxon_d;
			if (len_we)  len_q[arr_idx]  <= clen_q;
			if (pend_we) pend_q[arr_idx] <= tx_ch;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			// a read shows the entry before the pop
			bufv_s2   <= (action_q == smrxtx_pkg::ACT_READ) ? (fill_q != '0) : (fill_d != '0);
			strobe_s2 <= strobe;
			txline_s2 <= strobe ? sel_q : '0;
			txdata_s2 <= strobe ? tx_ch : '0;
		end
	end

	smrxtx_silo #(
		.DEPTH (SILO_DEPTH)
	) u_silo (
		.clk     (clk),
		.wr_en   (wr_en && exec_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (tail_q),
		.rd_data (head_entry)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.buf_valid     <= bufv_s2;
			rsp.buf_line      <= bufv_s2 ? head_entry.line : '0;
			rsp.buf_overrun   <= bufv_s2 ? head_entry.ovr : 1'b0;
			rsp.buf_data      <= bufv_s2 ? head_entry.ch : '0;
			rsp.silo_alarm    <= alarm_q;
			rsp.tx_ready_flag <= ready_q;
			rsp.tx_select     <= sel_q;
			rsp.rx_irq        <= alarm_md_q ? alarm_q : (rxirq_en_q && (fill_q != '0));
			rsp.tx_irq        <= txirq_en_q && ready_q;
			rsp.tx_strobe     <= strobe_s2;
			rsp.tx_line       <= txline_s2;
			rsp.tx_data       <= txdata_s2;
		end
	end

	assign rsp.valid = out_valid_q;

`ifndef SYNTHESIS
	logic [7:0] ok_chk;
	assign ok_chk = 8'(en_q & idle_q);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(SILO_DEPTH))
		else $error("silo fill above depth");

	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == FILL_W'(SILO_DEPTH)) |-> head_q == tail_q)
		else $error("pointers disagree with fill level");

	a_ready_line: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (sel_q < NUM_LINES) && ok_chk[sel_q])
		else $error("ready set on a line that is not enabled and idle");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> st_q == smrxtx_pkg::ST_EXEC)
		else $error("accepted word not executed");

	a_no_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == smrxtx_pkg::ST_EXEC |-> !req.ready)
		else $error("word accepted while another executes");
`endif

endmodule

// ===== verif/smrxtx_checker.sv =====
module smrxtx_checker
	import smrxtx_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	smrxtx_in_if   req,
	smrxtx_out_if  rsp,
	smrxtx_cfg_if  cfg,
	output int     fail_count,
	output int     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SILO   = SILO_DEPTH_DEF;
	localparam int NLINES = NUM_LINES_DEF;
	localparam int STEP   = ALARM_STEP_DEF;

	typedef struct packed {
		logic              buf_valid;
		logic [LINE_W-1:0] buf_line;
		logic              buf_overrun;
		logic [CHAR_W-1:0] buf_data;
		logic              silo_alarm;
		logic              tx_ready_flag;
		logic [LINE_W-1:0] tx_select;
		logic              rx_irq;
		logic              tx_irq;
		logic              tx_strobe;
		logic [LINE_W-1:0] tx_line;
		logic [CHAR_W-1:0] tx_data;
	} mux_status_t;

	// silo and scanner state as the block should hold it
	logic [CHAR_W-1:0] silo_ch [SILO];
	logic [LINE_W-1:0] silo_ln [SILO];
	logic              silo_ov [SILO];
	int unsigned       wr_ptr, rd_ptr, level, alarm_at;
	logic              alarm, tx_rdy;
	logic [LINE_W-1:0] sel;
	logic [7:0]        enables, idle, rxon_mask;
	logic [CLEN_W-1:0] len_code [NLINES];
	logic [CHAR_W-1:0] pending_ch [NLINES];
	logic              scan_en, rxirq_en, alarm_md, txirq_en, loop_en;

	mux_status_t status_q[$];
	int mismatches = 0;
	int waiting = 0;

	assign fail_count  = mismatches;
	assign outstanding = waiting;

	function automatic logic [CHAR_W-1:0] char_mask(input logic [CLEN_W-1:0] code);
		return 8'hFF >> (2'd3 - code);
	endfunction

	function automatic logic line_free(input int ln);
		return enables[ln] && idle[ln];
	endfunction

	function automatic string show(input mux_status_t s);
		return $sformatf({"buf v%0b ln%0d ovr%0b d%02h alarm %0b rdy %0b sel %0d ",
			"irq rx%0b tx%0b strobe %0b ln%0d d%02h"},
			s.buf_valid, s.buf_line, s.buf_overrun, s.buf_data, s.silo_alarm,
			s.tx_ready_flag, s.tx_select, s.rx_irq, s.tx_irq, s.tx_strobe,
			s.tx_line, s.tx_data);
	endfunction

	task automatic clear_model();
		wr_ptr = 0; rd_ptr = 0; level = 0; alarm_at = STEP;
		alarm = 1'b0; tx_rdy = 1'b0; sel = '0;
		enables = '0; idle = '1; rxon_mask = '0;
		for (int i = 0; i < NLINES; i++) begin
			len_code[i] = '0;
			pending_ch[i] = '0;
		end
		scan_en = 1'b0; rxirq_en = 1'b0; alarm_md = 1'b0; txirq_en = 1'b0; loop_en = 1'b0;
	endtask

	// full silo: newest entry is overwritten and flagged
	task automatic receive(input logic [LINE_W-1:0] ln, input logic [CHAR_W-1:0] ch);
		int unsigned p;
		if (!(scan_en && rxon_mask[ln]))
			return;
		ch = ch & char_mask(len_code[ln]);
		if (level < SILO) begin
			silo_ch[wr_ptr] = ch;
			silo_ln[wr_ptr] = ln;
			silo_ov[wr_ptr] = 1'b0;
			wr_ptr = (wr_ptr + 1) % SILO;
			level++;
			if (level >= alarm_at)
				alarm = 1'b1;
		end else begin
			p = (wr_ptr == 0) ? SILO - 1 : wr_ptr - 1;
			silo_ch[p] = ch;
			silo_ln[p] = ln;
			silo_ov[p] = 1'b1;
		end
	endtask

	// keep the current line while it still qualifies, else take the highest one
	task automatic rescan();
		if (tx_rdy && line_free(sel))
			return;
		for (int i = NLINES - 1; i >= 0; i--) begin
			if (line_free(i)) begin
				tx_rdy = 1'b1;
				sel = LINE_W'(i);
				return;
			end
		end
		tx_rdy = 1'b0;
	endtask

	task automatic head_fields(inout mux_status_t e);
		if (level > 0) begin
			e.buf_valid = 1'b1;
			e.buf_line = silo_ln[rd_ptr];
			e.buf_overrun = silo_ov[rd_ptr];
			e.buf_data = silo_ch[rd_ptr];
		end else begin
			e.buf_valid = 1'b0;
			e.buf_line = '0;
			e.buf_overrun = 1'b0;
			e.buf_data = '0;
		end
	endtask

	task automatic predict_status(input logic [ACTION_W-1:0] act, input logic [LINE_W-1:0] ln,
			input logic [CHAR_W-1:0] d, input logic [7:0] em, input logic [CLEN_W-1:0] cl,
			input logic rx, output mux_status_t e);
		e = '0;
		// a read reports the head as it was before the pop
		if (act == ACT_READ)
			head_fields(e);
		case (act)
			ACT_RX: receive(ln, d);
			ACT_READ: begin
				alarm = 1'b0;
				if (level > 0) begin
					rd_ptr = (rd_ptr + 1) % SILO;
					level--;
				end
				alarm_at = level + STEP;
			end
			ACT_ENABLES: begin
				enables = em;
				rescan();
			end
			ACT_TXWR: begin
				tx_rdy = 1'b0;
				if (idle[sel]) begin
					idle[sel] = 1'b0;
					pending_ch[sel] = d & char_mask(len_code[sel]);
					e.tx_strobe = 1'b1;
					e.tx_line = sel;
					e.tx_data = pending_ch[sel];
				end
				rescan();
			end
			ACT_TXDONE: begin
				if (!idle[ln]) begin
					if (loop_en)
						receive(ln, pending_ch[ln]);
					idle[ln] = 1'b1;
					rescan();
				end
			end
			ACT_PARAMS: begin
				len_code[ln] = cl;
				rxon_mask[ln] = rx;
			end
			default: ;
		endcase
		if (act != ACT_READ)
			head_fields(e);
		e.silo_alarm = alarm;
		e.tx_ready_flag = tx_rdy;
		e.tx_select = sel;
		e.rx_irq = alarm_md ? alarm : (rxirq_en && level > 0);
		e.tx_irq = txirq_en && tx_rdy;
	endtask

	task automatic note_fail(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%t: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		mux_status_t exp_w, got_w;
		if (!arst_n) begin
			clear_model();
			status_q.delete();
			waiting = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_SCAN_EN:  scan_en = cfg.wdata;
					CFG_RXIRQ_EN: rxirq_en = cfg.wdata;
					CFG_ALARM_MD: alarm_md = cfg.wdata;
					CFG_TXIRQ_EN: txirq_en = cfg.wdata;
					CFG_LOOPBACK: loop_en = cfg.wdata;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				got_w = {rsp.buf_valid, rsp.buf_line, rsp.buf_overrun, rsp.buf_data,
					rsp.silo_alarm, rsp.tx_ready_flag, rsp.tx_select, rsp.rx_irq,
					rsp.tx_irq, rsp.tx_strobe, rsp.tx_line, rsp.tx_data};
				if (status_q.size() == 0) begin
					note_fail({"status word with nothing pending: ", show(got_w)});
				end else begin
					exp_w = status_q.pop_front();
					if (got_w !== exp_w)
						note_fail({"status mismatch\n  exp ", show(exp_w),
							"\n  got ", show(got_w)});
				end
			end
			if (req.valid && req.ready) begin
				predict_status(req.action, req.line, req.data, req.enable_mask,
					req.width_code, req.rx_on, exp_w);
				status_q.push_back(exp_w);
			end
			waiting = status_q.size();
		end
	end

endmodule

// ===== verif/tb_serial_mux_rx_silo_tx_scanner.sv =====
module tb_serial_mux_rx_silo_tx_scanner;
	import smrxtx_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// spare action codes, no effect on the block
	localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;

	localparam int MIX_GENERAL = 0;
	localparam int MIX_FILL    = 1;
	localparam int MIX_DRAIN   = 2;

	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count, outstanding;
	int   req_gap_max, rsp_gap_max;
	bit   long_hold;

	smrxtx_in_if  req_if ();
	smrxtx_out_if rsp_if ();
	smrxtx_cfg_if cfg_if ();

	serial_mux_rx_silo_tx_scanner u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	smrxtx_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.rsp         (rsp_if),
		.cfg         (cfg_if),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// status word receiver: random stalls, one long hold-off on request
	initial begin
		int n;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				n = LONG_HOLD;
				long_hold = 1'b0;
			end else begin
				n = $urandom_range(0, rsp_gap_max);
			end
			if (n != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(input logic [ACTION_W-1:0] act, input logic [LINE_W-1:0] ln,
			input logic [CHAR_W-1:0] d, input logic [7:0] em, input logic [CLEN_W-1:0] cl,
			input logic rx);
		int gap;
		gap = $urandom_range(0, req_gap_max);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.action      <= act;
		req_if.line        <= ln;
		req_if.data        <= d;
		req_if.enable_mask <= em;
		req_if.width_code  <= cl;
		req_if.rx_on       <= rx;
		do @(posedge clk); while (!req_if.ready);
		@(negedge clk);
	endtask

	task automatic send_rand(input int n, input int mix);
		logic [ACTION_W-1:0] act;
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			case (mix)
				MIX_FILL:
					act = pick < 85 ? ACT_RX : pick < 90 ? ACT_PARAMS :
						pick < 95 ? ACT_TXWR : ACT_TXDONE;
				MIX_DRAIN:
					act = pick < 70 ? ACT_READ : pick < 90 ? ACT_RX :
						pick < 95 ? ACT_TXDONE : ACT_ENABLES;
				default:
					act = pick < 30 ? ACT_RX : pick < 52 ? ACT_READ :
						pick < 60 ? ACT_ENABLES : pick < 74 ? ACT_TXWR :
						pick < 88 ? ACT_TXDONE : pick < 96 ? ACT_PARAMS :
						pick < 98 ? ACT_SPARE6 : ACT_SPARE7;
			endcase
			send_word(act, LINE_W'($urandom_range(0, 7)), CHAR_W'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), CLEN_W'($urandom_range(0, 3)),
				$urandom_range(0, 9) != 0);
		end
	endtask

	// block must be idle before any register write
	task automatic settle();
		int guard;
		guard = 0;
		req_if.valid <= 1'b0;
		while (outstanding != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_regs(input logic scan, input logic rxirq, input logic alarm,
			input logic txirq, input logic loop);
		cfg_reg_t   regs [5] = '{CFG_SCAN_EN, CFG_RXIRQ_EN, CFG_ALARM_MD, CFG_TXIRQ_EN,
			CFG_LOOPBACK};
		logic [4:0] vals;
		vals = {loop, txirq, alarm, rxirq, scan};
		for (int i = 0; i < 5; i++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= regs[i];
			cfg_if.wdata <= vals[i];
			do @(posedge clk); while (!cfg_if.ready);
			@(negedge clk);
		end
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = ACT_RX;
		req_if.line = '0;
		req_if.data = '0;
		req_if.enable_mask = '0;
		req_if.width_code = '0;
		req_if.rx_on = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_SCAN_EN;
		cfg_if.wdata = 1'b0;
		req_gap_max = 17;
		rsp_gap_max = 17;
		long_hold = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_regs(1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
		send_word(ACT_READ,    3'd0, 8'h00, 8'h00, 2'd0, 1'b0);  // empty silo read
		send_word(ACT_PARAMS,  3'd0, 8'hFF, 8'hFF, 2'd0, 1'b1);
		send_word(ACT_PARAMS,  3'd7, 8'h00, 8'h00, 2'd3, 1'b1);
		send_word(ACT_RX,      3'd0, 8'hFF, 8'h00, 2'd3, 1'b0);  // 5-bit line
		send_word(ACT_RX,      3'd7, 8'hFF, 8'h00, 2'd0, 1'b0);
		send_word(ACT_RX,      3'd3, 8'hAA, 8'h00, 2'd0, 1'b1);  // receiver off
		send_word(ACT_ENABLES, 3'd0, 8'h00, 8'hFF, 2'd0, 1'b0);
		send_word(ACT_TXWR,    3'd0, 8'hFF, 8'h00, 2'd0, 1'b0);
		send_word(ACT_TXWR,    3'd0, 8'h00, 8'h00, 2'd0, 1'b0);
		send_word(ACT_TXDONE,  3'd7, 8'h00, 8'h00, 2'd0, 1'b0);  // loops back
		send_word(ACT_TXDONE,  3'd7, 8'h00, 8'h00, 2'd0, 1'b0);  // already idle
		send_word(ACT_ENABLES, 3'd0, 8'h00, 8'h00, 2'd0, 1'b0);  // nothing qualifies
		send_word(ACT_TXWR,    3'd0, 8'h5A, 8'h00, 2'd0, 1'b0);
		send_word(ACT_TXWR,    3'd0, 8'hA5, 8'h00, 2'd0, 1'b0);  // line busy, dropped
		send_word(ACT_SPARE6,  3'd7, 8'hFF, 8'hFF, 2'd3, 1'b1);
		send_word(ACT_SPARE7,  3'd7, 8'hFF, 8'hFF, 2'd3, 1'b1);
		send_word(ACT_READ,    3'd0, 8'h00, 8'h00, 2'd0, 1'b0);
		send_word(ACT_READ,    3'd0, 8'h00, 8'h00, 2'd0, 1'b0);
		send_word(ACT_READ,    3'd0, 8'h00, 8'h00, 2'd0, 1'b0);
		send_word(ACT_TXDONE,  3'd6, 8'h00, 8'h00, 2'd0, 1'b0);
		send_word(ACT_TXDONE,  3'd5, 8'h00, 8'h00, 2'd0, 1'b0);
		send_word(ACT_PARAMS,  3'd3, 8'h00, 8'h00, 2'd2, 1'b1);
		send_word(ACT_RX,      3'd3, 8'hFF, 8'h00, 2'd0, 1'b0);
		send_word(ACT_READ,    3'd0, 8'h00, 8'h00, 2'd0, 1'b0);
		settle();

		write_regs(1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
		send_rand(90, MIX_GENERAL);
		settle();

		// everything off, no idling on either side
		write_regs(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		req_gap_max = 0;
		rsp_gap_max = 0;
		send_rand(60, MIX_GENERAL);
		settle();

		// overrun the silo, then drain it with the alarm driving the irq
		write_regs(1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
		req_gap_max = 17;
		rsp_gap_max = 17;
		for (int ln = 0; ln < 8; ln++)
			send_word(ACT_PARAMS, LINE_W'(ln), CHAR_W'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), CLEN_W'($urandom_range(0, 3)), 1'b1);
		send_rand(90, MIX_FILL);
		send_rand(90, MIX_DRAIN);
		settle();

		// receiver holds off while words keep coming
		write_regs(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
		req_gap_max = 2;
		long_hold = 1'b1;
		send_rand(40, MIX_FILL);
		req_gap_max = 17;
		send_rand(50, MIX_GENERAL);
		settle();

		write_regs(1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
		send_rand(90, MIX_GENERAL);
		settle();

		if (outstanding != 0)
			$display("%0d status words never returned", outstanding);
		if (fail_count == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
